FILE: sv/tssg_pkg.sv
package tssg_pkg;

  localparam int ACC_W = 32;
  localparam int DEF_COORD_FRAC_BITS = 4;
  localparam int DEF_SLOPE_FRAC_BITS = 16;
  localparam int DEF_COORD_WIDTH = 16;
  localparam int COLOUR_W = 8;

  localparam logic KIND_LOAD = 1'b0;
  localparam logic KIND_ADVANCE = 1'b1;

  typedef enum logic [1:0] {
    SEL_A = 2'd0,
    SEL_B = 2'd1,
    SEL_C = 2'd2
  } div_sel_t;

  typedef struct packed {
    logic     load;
    logic     div_start;
    div_sel_t div_sel;
    logic     wr_two;
    logic     wr_one;
    logic     mul;
    logic     init_upper;
    logic     init_lower;
    logic     advance;
    logic     adv_last;
  } tssg_cmd_t;

  typedef struct packed {
    logic flat;
    logic upper_flat;
    logic lower_more;
    logic at_end;
    logic div_done;
  } tssg_status_t;

endpackage

FILE: sv/tssg_div.sv
module tssg_div
  import tssg_pkg::*;
#(
  parameter int COORD_WIDTH = DEF_COORD_WIDTH,
  parameter int SLOPE_FRAC_BITS = DEF_SLOPE_FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  input  logic signed [COORD_WIDTH:0]   num,
  input  logic signed [COORD_WIDTH:0]   den,
  output logic                          done,
  output logic signed [ACC_W-1:0]       quot
);

  localparam int DW = COORD_WIDTH + 1;
  localparam int NW = DW + SLOPE_FRAC_BITS;
  localparam int QW = ((NW > ACC_W) ? NW : ACC_W) + 1;
  localparam int CNT_W = $clog2(NW + 1);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(NW);
  localparam logic signed [QW-1:0] Q_MAX = {{(QW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [QW-1:0] Q_MIN = {{(QW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};

  logic             busy_r;
  logic [CNT_W-1:0] cnt_r;
  logic [NW-1:0]    n_r;
  logic [DW-1:0]    d_r;
  logic [DW-1:0]    rem_r;
  logic [NW-1:0]    q_r;
  logic             neg_r;
  logic             zero_r;
  logic             done_r;
  logic signed [ACC_W-1:0] quot_r;

  logic [DW-1:0]    abs_num;
  logic [DW-1:0]    abs_den;
  logic [DW:0]      trial;
  logic [DW:0]      diff;
  logic             qbit;
  logic signed [QW-1:0] qext;
  logic signed [QW-1:0] qsig;
  logic signed [ACC_W-1:0] qsat;

  assign abs_num = num[DW-1] ? DW'(-num) : DW'(num);
  assign abs_den = den[DW-1] ? DW'(-den) : DW'(den);
  assign trial = {rem_r, n_r[NW-1]};
  assign diff = trial - {1'b0, d_r};
  assign qbit = !diff[DW];

  always_comb begin
    qext = $signed({{(QW-NW){1'b0}}, q_r});
    qsig = neg_r ? -qext : qext;
    if (zero_r) begin
      qsat = '0;
    end else if (qsig > Q_MAX) begin
      qsat = Q_MAX[ACC_W-1:0];
    end else if (qsig < Q_MIN) begin
      qsat = Q_MIN[ACC_W-1:0];
    end else begin
      qsat = qsig[ACC_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r <= '0;
      end else if (busy_r) begin
        if (cnt_r == CNT_LAST) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end else begin
          cnt_r <= cnt_r + 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r <= {abs_num, {SLOPE_FRAC_BITS{1'b0}}};
      d_r <= abs_den;
      rem_r <= '0;
      q_r <= '0;
      neg_r <= num[DW-1] ^ den[DW-1];
      zero_r <= (den == '0);
    end else if (busy_r) begin
      if (cnt_r == CNT_LAST) begin
        quot_r <= qsat;
      end else begin
        rem_r <= qbit ? diff[DW-1:0] : trial[DW-1:0];
        n_r <= {n_r[NW-2:0], 1'b0};
        q_r <= {q_r[NW-2:0], qbit};
      end
    end
  end

  assign done = done_r;
  assign quot = quot_r;

endmodule

FILE: sv/tssg_dp.sv
module tssg_dp
  import tssg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int SLOPE_FRAC_BITS = DEF_SLOPE_FRAC_BITS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  tssg_cmd_t                                     cmd,
  output tssg_status_t                                  status,
  input  logic signed [COORD_WIDTH-1:0]                 ax,
  input  logic signed [COORD_WIDTH-1:0]                 ay,
  input  logic signed [COORD_WIDTH-1:0]                 bx,
  input  logic signed [COORD_WIDTH-1:0]                 by,
  input  logic signed [COORD_WIDTH-1:0]                 cx,
  input  logic signed [COORD_WIDTH-1:0]                 cy,
  input  logic [COLOUR_W-1:0]                           fill_colour,
  output logic signed [COORD_WIDTH-COORD_FRAC_BITS-1:0] span_row,
  output logic signed [COORD_WIDTH-1:0]                 span_x_from,
  output logic signed [COORD_WIDTH-1:0]                 span_x_to,
  output logic [COLOUR_W-1:0]                           span_colour,
  output logic                                          last_span
);

  localparam int CW = COORD_WIDTH;
  localparam int RW = COORD_WIDTH - COORD_FRAC_BITS;
  localparam int DW = CW + 1;
  localparam int BW = DW + ACC_W;
  localparam int LW = BW + 1;
  localparam int XSH = SLOPE_FRAC_BITS - COORD_FRAC_BITS;
  localparam logic [CW-1:0] FRAC_MASK = CW'((1 << COORD_FRAC_BITS) - 1);
  localparam logic signed [LW-1:0] A_MAX = {{(LW-ACC_W+1){1'b0}}, {(ACC_W-1){1'b1}}};
  localparam logic signed [LW-1:0] A_MIN = {{(LW-ACC_W+1){1'b1}}, {(ACC_W-1){1'b0}}};
  localparam logic signed [ACC_W-1:0] X_MAX = {{(ACC_W-CW+1){1'b0}}, {(CW-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] X_MIN = {{(ACC_W-CW+1){1'b1}}, {(CW-1){1'b0}}};

  function automatic logic signed [RW-1:0] row_of(input logic signed [CW-1:0] y);
    logic signed [CW-1:0] q;
    q = y >>> COORD_FRAC_BITS;
    if (y[CW-1] && ((y & FRAC_MASK) != '0)) begin
      q = q + 1'b1;
    end
    return q[RW-1:0];
  endfunction

  function automatic logic signed [ACC_W-1:0] sat_acc(input logic signed [LW-1:0] v);
    if (v > A_MAX) begin
      return A_MAX[ACC_W-1:0];
    end else if (v < A_MIN) begin
      return A_MIN[ACC_W-1:0];
    end else begin
      return v[ACC_W-1:0];
    end
  endfunction

  function automatic logic signed [LW-1:0] widen(input logic signed [CW-1:0] x);
    logic signed [LW-1:0] t;
    t = $signed({{(LW-CW){x[CW-1]}}, x});
    return t <<< XSH;
  endfunction

  function automatic logic signed [LW-1:0] ext_acc(input logic signed [ACC_W-1:0] a);
    return $signed({{(LW-ACC_W){a[ACC_W-1]}}, a});
  endfunction

  function automatic logic signed [CW-1:0] narrow(input logic signed [ACC_W-1:0] a);
    logic signed [ACC_W-1:0] v;
    v = a >>> XSH;
    if (v > X_MAX) begin
      return X_MAX[CW-1:0];
    end else if (v < X_MIN) begin
      return X_MIN[CW-1:0];
    end else begin
      return v[CW-1:0];
    end
  endfunction

  logic signed [CW-1:0] s1_0x, s1_0y, s1_1x, s1_1y;
  logic signed [CW-1:0] s2_0x, s2_0y, s2_2x, s2_2y;
  logic signed [CW-1:0] s3_1x, s3_1y, s3_2x, s3_2y;

  logic signed [CW-1:0] v0x_r, v0y_r, v1x_r, v1y_r, v2x_r, v2y_r;
  logic [COLOUR_W-1:0]  colour_r;
  logic signed [RW-1:0] cur_row_r, end_row_r;
  logic signed [ACC_W-1:0] e1x_r, e2x_r, e1s_r, e2s_r;
  logic signed [BW-1:0] prod_r;

  logic signed [RW-1:0] out_row_r;
  logic signed [CW-1:0] out_from_r, out_to_r;
  logic [COLOUR_W-1:0]  out_colour_r;
  logic                 out_last_r;

  logic signed [RW-1:0] r1, r2, r3;
  logic signed [DW-1:0] div_num, div_den;
  logic signed [DW-1:0] dy_low;
  logic signed [BW-1:0] back;
  logic                 div_done;
  logic signed [ACC_W-1:0] div_q;

  always_comb begin
    if (ay > by) begin
      s1_0x = bx; s1_0y = by; s1_1x = ax; s1_1y = ay;
    end else begin
      s1_0x = ax; s1_0y = ay; s1_1x = bx; s1_1y = by;
    end
    if (s1_0y > cy) begin
      s2_0x = cx; s2_0y = cy; s2_2x = s1_0x; s2_2y = s1_0y;
    end else begin
      s2_0x = s1_0x; s2_0y = s1_0y; s2_2x = cx; s2_2y = cy;
    end
    if (s1_1y > s2_2y) begin
      s3_1x = s2_2x; s3_1y = s2_2y; s3_2x = s1_1x; s3_2y = s1_1y;
    end else begin
      s3_1x = s1_1x; s3_1y = s1_1y; s3_2x = s2_2x; s3_2y = s2_2y;
    end
  end

  assign r1 = row_of(v0y_r);
  assign r2 = row_of(v1y_r);
  assign r3 = row_of(v2y_r);

  always_comb begin
    case (cmd.div_sel)
      SEL_A: begin
        div_num = DW'(v1x_r) - DW'(v0x_r);
        div_den = DW'(v1y_r) - DW'(v0y_r);
      end
      SEL_B: begin
        div_num = DW'(v2x_r) - DW'(v0x_r);
        div_den = DW'(v2y_r) - DW'(v0y_r);
      end
      SEL_C: begin
        div_num = DW'(v2x_r) - DW'(v1x_r);
        div_den = DW'(v2y_r) - DW'(v1y_r);
      end
      default: begin
        div_num = '0;
        div_den = '0;
      end
    endcase
  end

  assign dy_low = DW'(v2y_r) - DW'(v1y_r);
  assign back = prod_r >>> COORD_FRAC_BITS;

  tssg_div #(
    .COORD_WIDTH(COORD_WIDTH),
    .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS)
  ) u_div (
    .clk(clk),
    .rst_n(rst_n),
    .start(cmd.div_start),
    .num(div_num),
    .den(div_den),
    .done(div_done),
    .quot(div_q)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_row_r <= '0;
      end_row_r <= '0;
      e1x_r <= '0;
      e2x_r <= '0;
      e1s_r <= '0;
      e2s_r <= '0;
      colour_r <= '0;
    end else begin
      if (cmd.load) begin
        v0x_r <= s2_0x; v0y_r <= s2_0y;
        v1x_r <= s3_1x; v1y_r <= s3_1y;
        v2x_r <= s3_2x; v2y_r <= s3_2y;
        colour_r <= fill_colour;
      end
      if (cmd.wr_two) begin
        e2s_r <= div_q;
      end
      if (cmd.wr_one) begin
        e1s_r <= div_q;
      end
      if (cmd.mul) begin
        prod_r <= BW'(dy_low) * BW'(e2s_r);
      end
      if (cmd.init_upper) begin
        e1x_r <= sat_acc(widen(v0x_r));
        e2x_r <= sat_acc(widen(v0x_r));
        cur_row_r <= r1;
        end_row_r <= r2;
      end
      if (cmd.init_lower) begin
        e1s_r <= e2s_r;
        e2s_r <= div_q;
        e1x_r <= sat_acc(widen(v2x_r) - $signed({back[BW-1], back}));
        e2x_r <= sat_acc(widen(v1x_r));
        cur_row_r <= r2;
        end_row_r <= r3;
      end
      if (cmd.advance) begin
        out_row_r <= cur_row_r;
        out_from_r <= narrow(e1x_r);
        out_to_r <= narrow(e2x_r);
        out_colour_r <= colour_r;
        out_last_r <= cmd.adv_last;
        if (!status.at_end) begin
          cur_row_r <= cur_row_r + 1'b1;
          e1x_r <= sat_acc(ext_acc(e1x_r) + ext_acc(e1s_r));
          e2x_r <= sat_acc(ext_acc(e2x_r) + ext_acc(e2s_r));
        end
      end
    end
  end

  assign status.flat = (r1 == r3);
  assign status.upper_flat = (r1 == r2);
  assign status.lower_more = (r2 != r3);
  assign status.at_end = (cur_row_r >= end_row_r);
  assign status.div_done = div_done;

  assign span_row = out_row_r;
  assign span_x_from = out_from_r;
  assign span_x_to = out_to_r;
  assign span_colour = out_colour_r;
  assign last_span = out_last_r;

endmodule

FILE: sv/tssg_ctrl.sv
module tssg_ctrl
  import tssg_pkg::*;
(
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_valid,
  input  logic         in_kind,
  output logic         in_stall,
  output logic         out_valid,
  input  logic         out_stall,
  input  tssg_status_t status,
  output tssg_cmd_t    cmd
);

  typedef enum logic [6:0] {
    S_IDLE  = 7'b0000001,
    S_LOAD  = 7'b0000010,
    S_DIVB  = 7'b0000100,
    S_DIVA  = 7'b0001000,
    S_MUL   = 7'b0010000,
    S_DIVC  = 7'b0100000,
    S_SPANS = 7'b1000000
  } state_t;

  state_t state_r, state_nxt;
  logic   upper_r, upper_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   busy;
  logic   accept;
  logic   more;

  assign busy = (state_r == S_LOAD) || (state_r == S_DIVB) || (state_r == S_DIVA) ||
                (state_r == S_MUL) || (state_r == S_DIVC);
  assign in_stall = busy || (out_valid_r && out_stall);
  assign accept = in_valid && !in_stall;
  assign more = upper_r && status.lower_more;

  always_comb begin
    state_nxt = state_r;
    upper_nxt = upper_r;
    out_valid_nxt = out_valid_r && out_stall;
    cmd = '0;
    cmd.div_sel = SEL_B;
    case (state_r)
      S_IDLE, S_SPANS: begin
        if (accept && (in_kind == KIND_LOAD)) begin
          cmd.load = 1'b1;
          state_nxt = S_LOAD;
        end else if (accept && (state_r == S_SPANS)) begin
          cmd.advance = 1'b1;
          cmd.adv_last = status.at_end && !more;
          out_valid_nxt = 1'b1;
          if (status.at_end) begin
            state_nxt = more ? S_MUL : S_IDLE;
          end
        end
      end
      S_LOAD: begin
        if (status.flat) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.div_start = 1'b1;
          cmd.div_sel = SEL_B;
          state_nxt = S_DIVB;
        end
      end
      S_DIVB: begin
        cmd.div_sel = SEL_B;
        if (status.div_done) begin
          cmd.wr_two = 1'b1;
          if (status.upper_flat) begin
            state_nxt = S_MUL;
          end else begin
            cmd.div_start = 1'b1;
            cmd.div_sel = SEL_A;
            state_nxt = S_DIVA;
          end
        end
      end
      S_DIVA: begin
        cmd.div_sel = SEL_A;
        if (status.div_done) begin
          cmd.wr_one = 1'b1;
          cmd.init_upper = 1'b1;
          upper_nxt = 1'b1;
          state_nxt = S_SPANS;
        end
      end
      S_MUL: begin
        cmd.mul = 1'b1;
        cmd.div_start = 1'b1;
        cmd.div_sel = SEL_C;
        state_nxt = S_DIVC;
      end
      S_DIVC: begin
        cmd.div_sel = SEL_C;
        if (status.div_done) begin
          cmd.init_lower = 1'b1;
          upper_nxt = 1'b0;
          state_nxt = S_SPANS;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      upper_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      upper_r <= upper_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule

FILE: sv/triangle_scanline_span_generator.sv
// Triangle span generator: a load item (kind 0) takes three Q12.4 vertices and a colour,
// sorts them by y and works out the edge slopes on one shared restoring divider, during
// which the input stalls; a load runs two divisions, plus a multiply when the upper half
// is flat, and a flat triangle runs none. Each advance item (kind 1) then yields the next
// span, and the input also stalls while a span is held by out_stall; the step from the
// upper to the lower half runs one multiply and one division, during which the input
// stalls. A load taken mid-triangle replaces it.
module triangle_scanline_span_generator
  import tssg_pkg::*;
#(
  parameter int COORD_FRAC_BITS = DEF_COORD_FRAC_BITS,
  parameter int SLOPE_FRAC_BITS = DEF_SLOPE_FRAC_BITS,
  parameter int COORD_WIDTH = DEF_COORD_WIDTH
) (
  input  logic                                          clk,
  input  logic                                          rst_n,
  input  logic                                          in_valid,
  output logic                                          in_stall,
  input  logic                                          in_kind,
  input  logic signed [COORD_WIDTH-1:0]                 in_ax,
  input  logic signed [COORD_WIDTH-1:0]                 in_ay,
  input  logic signed [COORD_WIDTH-1:0]                 in_bx,
  input  logic signed [COORD_WIDTH-1:0]                 in_by,
  input  logic signed [COORD_WIDTH-1:0]                 in_cx,
  input  logic signed [COORD_WIDTH-1:0]                 in_cy,
  input  logic [COLOUR_W-1:0]                           in_fill_colour,
  output logic                                          out_valid,
  input  logic                                          out_stall,
  output logic signed [COORD_WIDTH-COORD_FRAC_BITS-1:0] out_span_row,
  output logic signed [COORD_WIDTH-1:0]                 out_span_x_from,
  output logic signed [COORD_WIDTH-1:0]                 out_span_x_to,
  output logic [COLOUR_W-1:0]                           out_span_colour,
  output logic                                          out_last_span
);

  tssg_cmd_t    cmd;
  tssg_status_t status;

  tssg_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in_valid),
    .in_kind(in_kind),
    .in_stall(in_stall),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .cmd(cmd)
  );

  tssg_dp #(
    .COORD_FRAC_BITS(COORD_FRAC_BITS),
    .SLOPE_FRAC_BITS(SLOPE_FRAC_BITS),
    .COORD_WIDTH(COORD_WIDTH)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .status(status),
    .ax(in_ax),
    .ay(in_ay),
    .bx(in_bx),
    .by(in_by),
    .cx(in_cx),
    .cy(in_cy),
    .fill_colour(in_fill_colour),
    .span_row(out_span_row),
    .span_x_from(out_span_x_from),
    .span_x_to(out_span_x_to),
    .span_colour(out_span_colour),
    .last_span(out_last_span)
  );

endmodule
